// File: rtl/mcm_pkg.sv
// shared constants, controller states and command/status types for the matrix chain cost block
`timescale 1ns / 1ps

package mcm_pkg;

  localparam int MAX_DIMS  = 32;
  localparam int DIM_BITS  = 10;
  localparam int COST_BITS = 36;

  localparam int IDX_BITS  = $clog2(MAX_DIMS);
  localparam int CNT_BITS  = $clog2(MAX_DIMS + 1);
  localparam int SUM_BITS  = IDX_BITS + 1;
  localparam int TBL_DEPTH = 1 << (2 * IDX_BITS);
  localparam int PROD_BITS = 3 * DIM_BITS;
  localparam int WIDE_BITS = (PROD_BITS > COST_BITS) ? PROD_BITS : COST_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_ENTRY,
    ST_LO,
    ST_HI,
    ST_SPLIT,
    ST_MUL1,
    ST_MUL2,
    ST_CMP,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;    // store one dimension beat
    logic start;     // set up the length/position loops
    logic rd_lo;     // read dim[i-1], k = i
    logic cap_lo;    // capture dim[i-1], read dim[j]
    logic cap_hi;    // capture dim[j], reset running minimum
    logic rd_split;  // read dim[k] and both sub-chain costs
    logic mul1;      // dim[i-1] * dim[k]
    logic mul2;      // * dim[j], add sub-chain costs
    logic cmp;       // total and running minimum, next split
    logic write;     // store entry, next sub-chain
    logic emit;      // load the result register, clear the chain
  } cmd_t;

  typedef struct packed {
    logic short_chain;
    logic last_split;
    logic last_entry;
  } stat_t;

endpackage

// File: rtl/mcm_in_if.sv
// dimension input channel
`timescale 1ns / 1ps

interface mcm_in_if;
  logic                         valid;
  logic                         ready;
  logic [mcm_pkg::DIM_BITS-1:0] dimension;
  logic                         last;

  modport source (output valid, output dimension, output last, input ready);
  modport sink   (input valid, input dimension, input last, output ready);
endinterface

// File: rtl/mcm_out_if.sv
// result channel
`timescale 1ns / 1ps

interface mcm_out_if;
  logic                          valid;
  logic                          ready;
  logic [mcm_pkg::COST_BITS-1:0] min_cost;
  logic                          too_long;

  modport source (output valid, output min_cost, output too_long, input ready);
  modport sink   (input valid, input min_cost, input too_long, output ready);
endinterface

// File: rtl/mcm_datapath.sv
// dimension store, cost table, loop counters and cost arithmetic
`timescale 1ns / 1ps

module mcm_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcm_pkg::cmd_t                 cmd,
  output mcm_pkg::stat_t                stat,
  input  logic [mcm_pkg::DIM_BITS-1:0]  in_dimension,
  output logic [mcm_pkg::COST_BITS-1:0] out_min_cost,
  output logic                          out_too_long
);

  localparam logic [mcm_pkg::COST_BITS-1:0] COST_MAX = '1;

  logic [mcm_pkg::DIM_BITS-1:0]  dim_mem [mcm_pkg::MAX_DIMS];
  logic [mcm_pkg::COST_BITS-1:0] cost_mem [mcm_pkg::TBL_DEPTH];

  logic [mcm_pkg::CNT_BITS-1:0]    count_r;
  logic                            ovf_r;
  logic [mcm_pkg::IDX_BITS-1:0]    len_r, i_r, j_r, k_r;
  logic [mcm_pkg::DIM_BITS-1:0]    dim_rd_r, da_r, db_r;
  logic [mcm_pkg::COST_BITS-1:0]   cl_rd_r, cr_rd_r;
  logic                            lz_r, rz_r;
  logic [2*mcm_pkg::DIM_BITS-1:0]  prod1_r;
  logic [mcm_pkg::COST_BITS-1:0]   prod2_r, sumlr_r, best_r;
  logic [mcm_pkg::COST_BITS-1:0]   min_cost_r;
  logic                            too_long_r;

  logic [mcm_pkg::IDX_BITS-1:0]    dim_rd_addr;
  logic                            dim_rd_en;
  logic [mcm_pkg::IDX_BITS-1:0]    k_inc;
  logic [mcm_pkg::SUM_BITS-1:0]    count_ext, i_plus_len, len_plus_one;
  logic [mcm_pkg::PROD_BITS-1:0]   prod2_full;
  logic [mcm_pkg::WIDE_BITS-1:0]   prod2_wide;
  logic [mcm_pkg::COST_BITS-1:0]   prod2_sat, cl_eff, cr_eff;
  logic [mcm_pkg::COST_BITS:0]     sumlr_full, total_full;
  logic [mcm_pkg::COST_BITS-1:0]   sumlr_sat, total_sat;

  assign k_inc        = k_r + mcm_pkg::IDX_BITS'(1);
  assign count_ext    = mcm_pkg::SUM_BITS'(count_r);
  assign i_plus_len   = mcm_pkg::SUM_BITS'(i_r) + mcm_pkg::SUM_BITS'(len_r);
  assign len_plus_one = mcm_pkg::SUM_BITS'(len_r) + mcm_pkg::SUM_BITS'(1);

  assign stat.short_chain = (count_r < mcm_pkg::CNT_BITS'(3));
  assign stat.last_split  = (k_inc == j_r);
  assign stat.last_entry  = (len_plus_one == count_ext);

  always_comb begin
    dim_rd_en   = cmd.rd_lo | cmd.cap_lo | cmd.rd_split;
    dim_rd_addr = k_r;
    if (cmd.rd_lo) begin
      dim_rd_addr = i_r - mcm_pkg::IDX_BITS'(1);
    end else if (cmd.cap_lo) begin
      dim_rd_addr = j_r;
    end
  end

  // product saturates only when three dimensions outgrow the cost width
  assign prod2_full = mcm_pkg::PROD_BITS'(prod1_r) * mcm_pkg::PROD_BITS'(db_r);
  assign prod2_wide = mcm_pkg::WIDE_BITS'(prod2_full);
  assign prod2_sat  = (prod2_wide > mcm_pkg::WIDE_BITS'(COST_MAX)) ?
                      COST_MAX : mcm_pkg::COST_BITS'(prod2_wide);

  // diagonal entries are zero and are never stored
  assign cl_eff     = lz_r ? '0 : cl_rd_r;
  assign cr_eff     = rz_r ? '0 : cr_rd_r;
  assign sumlr_full = {1'b0, cl_eff} + {1'b0, cr_eff};
  assign sumlr_sat  = sumlr_full[mcm_pkg::COST_BITS] ?
                      COST_MAX : sumlr_full[mcm_pkg::COST_BITS-1:0];
  assign total_full = {1'b0, sumlr_r} + {1'b0, prod2_r};
  assign total_sat  = total_full[mcm_pkg::COST_BITS] ?
                      COST_MAX : total_full[mcm_pkg::COST_BITS-1:0];

  // memories
  always_ff @(posedge clk) begin
    if (cmd.accept && (count_r < mcm_pkg::CNT_BITS'(mcm_pkg::MAX_DIMS))) begin
      dim_mem[count_r[mcm_pkg::IDX_BITS-1:0]] <= in_dimension;
    end
    if (dim_rd_en) begin
      dim_rd_r <= dim_mem[dim_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      cost_mem[{i_r, j_r}] <= best_r;
    end
    if (cmd.rd_split) begin
      cl_rd_r <= cost_mem[{i_r, k_r}];
      cr_rd_r <= cost_mem[{k_inc, j_r}];
    end
  end

  // chain length and overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.emit) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.accept) begin
      if (count_r < mcm_pkg::CNT_BITS'(mcm_pkg::MAX_DIMS)) begin
        count_r <= count_r + mcm_pkg::CNT_BITS'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      i_r   <= '0;
      j_r   <= '0;
      k_r   <= '0;
    end else if (cmd.start) begin
      len_r <= mcm_pkg::IDX_BITS'(2);
      i_r   <= mcm_pkg::IDX_BITS'(1);
      j_r   <= mcm_pkg::IDX_BITS'(2);
    end else if (cmd.rd_lo) begin
      k_r <= i_r;
    end else if (cmd.cmp) begin
      k_r <= k_inc;
    end else if (cmd.write) begin
      if (i_plus_len < count_ext) begin
        i_r <= i_r + mcm_pkg::IDX_BITS'(1);
        j_r <= j_r + mcm_pkg::IDX_BITS'(1);
      end else begin
        len_r <= len_r + mcm_pkg::IDX_BITS'(1);
        i_r   <= mcm_pkg::IDX_BITS'(1);
        j_r   <= len_plus_one[mcm_pkg::IDX_BITS-1:0];
      end
    end
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_r <= '0;
    end else if (cmd.cap_hi) begin
      best_r <= COST_MAX;
    end else if (cmd.cmp && (total_sat < best_r)) begin
      best_r <= total_sat;
    end
    if (cmd.cap_lo) begin
      da_r <= dim_rd_r;
    end
    if (cmd.cap_hi) begin
      db_r <= dim_rd_r;
    end
    if (cmd.rd_split) begin
      lz_r <= (k_r == i_r);
      rz_r <= (k_inc == j_r);
    end
    if (cmd.mul1) begin
      prod1_r <= (2*mcm_pkg::DIM_BITS)'(da_r) * (2*mcm_pkg::DIM_BITS)'(dim_rd_r);
    end
    if (cmd.mul2) begin
      prod2_r <= prod2_sat;
      sumlr_r <= sumlr_sat;
    end
    if (cmd.emit) begin
      min_cost_r <= best_r;
      too_long_r <= ovf_r;
    end
  end

  assign out_min_cost = min_cost_r;
  assign out_too_long = too_long_r;

endmodule

// File: rtl/mcm_ctrl.sv
// sequencer: loads the chain, walks sub-chains by length and split point, issues the result
`timescale 1ns / 1ps

module mcm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output mcm_pkg::cmd_t  cmd,
  input  mcm_pkg::stat_t stat
);

  mcm_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            emit_ok;

  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcm_pkg::ST_IDLE: begin
        if (in_valid && in_last) begin
          state_nxt = mcm_pkg::ST_START;
        end
      end
      mcm_pkg::ST_START: begin
        state_nxt = stat.short_chain ? mcm_pkg::ST_DONE : mcm_pkg::ST_ENTRY;
      end
      mcm_pkg::ST_ENTRY: state_nxt = mcm_pkg::ST_LO;
      mcm_pkg::ST_LO:    state_nxt = mcm_pkg::ST_HI;
      mcm_pkg::ST_HI:    state_nxt = mcm_pkg::ST_SPLIT;
      mcm_pkg::ST_SPLIT: state_nxt = mcm_pkg::ST_MUL1;
      mcm_pkg::ST_MUL1:  state_nxt = mcm_pkg::ST_MUL2;
      mcm_pkg::ST_MUL2:  state_nxt = mcm_pkg::ST_CMP;
      mcm_pkg::ST_CMP: begin
        state_nxt = stat.last_split ? mcm_pkg::ST_WRITE : mcm_pkg::ST_SPLIT;
      end
      mcm_pkg::ST_WRITE: begin
        state_nxt = stat.last_entry ? mcm_pkg::ST_DONE : mcm_pkg::ST_ENTRY;
      end
      mcm_pkg::ST_DONE: begin
        if (emit_ok) begin
          state_nxt = mcm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      mcm_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      mcm_pkg::ST_START: cmd.start    = 1'b1;
      mcm_pkg::ST_ENTRY: cmd.rd_lo    = 1'b1;
      mcm_pkg::ST_LO:    cmd.cap_lo   = 1'b1;
      mcm_pkg::ST_HI:    cmd.cap_hi   = 1'b1;
      mcm_pkg::ST_SPLIT: cmd.rd_split = 1'b1;
      mcm_pkg::ST_MUL1:  cmd.mul1     = 1'b1;
      mcm_pkg::ST_MUL2:  cmd.mul2     = 1'b1;
      mcm_pkg::ST_CMP:   cmd.cmp      = 1'b1;
      mcm_pkg::ST_WRITE: cmd.write    = 1'b1;
      mcm_pkg::ST_DONE:  cmd.emit     = emit_ok;
      default: cmd = '0;
    endcase
  end

  // result beat stays until taken, the next chain may load meanwhile
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/matrix_chain_min_cost.sv
// top level: least scalar-multiplication count of a matrix chain
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    dimension[9:0], last
//   out_chan  out  valid/ready    min_cost[35:0], too_long
//
// dimension beats load one per cycle while idle; the beat with last starts the table fill
// the fill walks sub-chains by length; each split point reads dims and sub-chain costs,
// multiplies, then compares the total with the running minimum
// chains under three dims skip the fill and answer zero; in_ready is low during the fill
// a result held by out_chan stall does not block loading of the next chain
// rst_n is synchronous; store and cost table are not cleared
`timescale 1ns / 1ps

module matrix_chain_min_cost (
  input  logic       clk,
  input  logic       rst_n,
  mcm_in_if.sink     in_chan,
  mcm_out_if.source  out_chan
);

  mcm_pkg::cmd_t  cmd;
  mcm_pkg::stat_t stat;

  mcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_chan.last),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mcm_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_dimension (in_chan.dimension),
    .out_min_cost (out_chan.min_cost),
    .out_too_long (out_chan.too_long)
  );

endmodule

// File: tb/matrix_chain_min_cost_tb.sv
// testbench for matrix_chain_min_cost: random chains against a dynamic-programming cost predictor
`timescale 1ns / 1ps

module matrix_chain_min_cost_tb;
  import mcm_pkg::*;

  localparam int          HALF_PERIOD = 5;
  localparam int          ITEM_TARGET = 1450;
  localparam int          WAIT_MAX    = 17;
  localparam longint      CYCLE_LIMIT = 4000000;
  localparam int          TAIL_CYCLES = 64;
  localparam logic [63:0] COST_CAP    = (64'd1 << COST_BITS) - 64'd1;

  typedef logic [DIM_BITS-1:0]  dim_t;
  typedef logic [COST_BITS-1:0] cost_t;

  typedef struct {
    cost_t cost;
    logic  too_long;
  } chain_result_t;

  class chain_cost_board;
    dim_t          dims[$];
    bit            spilled;
    chain_result_t pending[$];
    int            errors;

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // bottom-up table over sub-chain length, every sum clamped at the cost width
    function cost_t least_mults();
      logic [63:0] tbl [MAX_DIMS][MAX_DIMS];
      logic [63:0] best;
      logic [63:0] prod;
      logic [63:0] sum;
      int          n;
      int          j;
      n = dims.size();
      if (n < 3) return '0;
      for (int i = 1; i < n; i++) tbl[i][i] = '0;
      for (int len = 2; len < n; len++) begin
        for (int i = 1; i + len - 1 < n; i++) begin
          j    = i + len - 1;
          best = COST_CAP;
          for (int k = i; k < j; k++) begin
            prod = 64'(dims[i-1]) * 64'(dims[k]);
            if (prod > COST_CAP) prod = COST_CAP;
            prod = prod * 64'(dims[j]);
            if (prod > COST_CAP) prod = COST_CAP;
            sum = tbl[i][k] + tbl[k+1][j];
            if (sum > COST_CAP) sum = COST_CAP;
            sum = sum + prod;
            if (sum > COST_CAP) sum = COST_CAP;
            if (sum < best) best = sum;
          end
          tbl[i][j] = best;
        end
      end
      return cost_t'(tbl[1][n-1]);
    endfunction

    function void note_beat(dim_t d, logic lst);
      chain_result_t r;
      if (dims.size() < MAX_DIMS) dims.push_back(d);
      else spilled = 1'b1;
      if (lst) begin
        r.cost     = least_mults();
        r.too_long = spilled;
        pending.push_back(r);
        dims.delete();
        spilled = 1'b0;
      end
    endfunction

    task check_result(cost_t cost, logic tl);
      chain_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result min_cost=%0d too_long=%0b", cost, tl));
        return;
      end
      want = pending.pop_front();
      if (cost !== want.cost)
        report($sformatf("min_cost got %0d want %0d", cost, want.cost));
      if (tl !== want.too_long)
        report($sformatf("too_long got %0b want %0b", tl, want.too_long));
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst_n;
  longint          cycles = 0;
  int              items_sent = 0;
  int              in_calm = 0;
  int              out_calm = 0;
  dim_t            chain_buf[$];
  chain_cost_board board = new();

  mcm_in_if  in_chan ();
  mcm_out_if out_chan ();

  matrix_chain_min_cost u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // idle cycles before a beat, with runs of back-to-back beats now and then
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(5, 40);
      return 0;
    end
    return $urandom_range(0, WAIT_MAX);
  endfunction

  task automatic send_beat(dim_t d, logic lst);
    int gap;
    gap = draw_wait(in_calm);
    repeat (gap) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.dimension <= d;
    in_chan.last      <= lst;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    board.note_beat(d, lst);
    items_sent++;
  endtask

  task automatic send_chain();
    foreach (chain_buf[i]) send_beat(chain_buf[i], i == chain_buf.size() - 1);
  endtask

  // flavors: full range, tiny values, sprinkled zeros, all at the top of the range
  function automatic void fill_chain(int len, int flavor);
    dim_t d;
    chain_buf.delete();
    repeat (len) begin
      if (flavor <= 5) d = dim_t'($urandom_range(1, (1 << DIM_BITS) - 1));
      else if (flavor <= 7) d = dim_t'($urandom_range(1, 8));
      else if (flavor == 8) d = ($urandom_range(0, 9) == 0) ? '0 : dim_t'($urandom);
      else d = '1;
      chain_buf.push_back(d);
    end
  endfunction

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  initial begin : result_sink
    int stall;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = draw_wait(out_calm);
      repeat (stall) begin
        out_chan.ready <= 1'b0;
        @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      board.check_result(out_chan.min_cost, out_chan.too_long);
    end
  end

  initial begin : stimulus
    int pick;
    int len;
    in_chan.valid     <= 1'b0;
    in_chan.dimension <= '0;
    in_chan.last      <= 1'b0;
    rst_n             <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // one and two dims cost nothing
    chain_buf = {DIM_BITS'(7)};
    send_chain();
    chain_buf = {DIM_BITS'(1023), DIM_BITS'(1023)};
    send_chain();
    chain_buf = {DIM_BITS'(1023), DIM_BITS'(1023), DIM_BITS'(1023)};
    send_chain();
    chain_buf = {DIM_BITS'(10), DIM_BITS'(30), DIM_BITS'(5), DIM_BITS'(60)};
    send_chain();
    // zero dims wipe out their products
    chain_buf = {DIM_BITS'(0), DIM_BITS'(5), DIM_BITS'(7), DIM_BITS'(0)};
    send_chain();
    chain_buf = {DIM_BITS'(1), DIM_BITS'(1023), DIM_BITS'(1), DIM_BITS'(1023), DIM_BITS'(1)};
    send_chain();
    chain_buf = {DIM_BITS'(40), DIM_BITS'(20), DIM_BITS'(30), DIM_BITS'(10), DIM_BITS'(30)};
    send_chain();
    drain_results();

    // full store at the largest dims, then a chain that spills past the store
    fill_chain(MAX_DIMS, 9);
    send_chain();
    fill_chain(MAX_DIMS + 4, 0);
    send_chain();

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) len = $urandom_range(1, 2);
      else if (pick < 80) len = $urandom_range(3, 12);
      else if (pick < 93) len = $urandom_range(13, 24);
      else if (pick < 97) len = $urandom_range(25, MAX_DIMS);
      else len = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 8);
      fill_chain(len, $urandom_range(0, 9));
      send_chain();
      if ($urandom_range(0, 11) == 0) drain_results();
    end

    in_chan.valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
